// ----- rtl/core/stereo_fir_filter_macros.svh -----
// assertion macros used by the stereo fir filter datapath
`ifndef STEREO_FIR_FILTER_MACROS_SVH
`define STEREO_FIR_FILTER_MACROS_SVH

// plain property on aclk, off while in reset
`define SFIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication on aclk
`define SFIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on aclk
`define SFIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sfir_pkg.sv -----
// types and constants of the stereo fir filter
package sfir_pkg;

    localparam int TAPS     = 64;
    localparam int IDX_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 6;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int RES_W    = 32;
    localparam int ACC_W    = PROD_W + IDX_W;
    localparam int S_FIELDS_W = TAP_W + 2 * SAMPLE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 2 * RES_W;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } sfir_state_t;

    typedef struct packed {
        logic load_coef;
        logic push_sample;
        logic issue;
        logic publish;
    } sfir_cmd_t;

    typedef struct packed {
        logic last_tap;
        logic pipe_empty;
        logic out_free;
    } sfir_status_t;

endpackage

// ----- rtl/core/sfir_ram.sv -----
// generic single-write, single-read ram with registered read data
module sfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/sfir_ctrl.sv -----
// controller state machine of the stereo fir filter
module sfir_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_command,
    output logic                  s_tready,
    input  sfir_pkg::sfir_status_t status,
    output sfir_pkg::sfir_cmd_t    cmd
);
    import sfir_pkg::*;

    sfir_state_t state_reg;
    sfir_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_command == CMD_SAMPLE) begin
                        cmd.push_sample = 1'b1;
                        state_next      = ST_RUN;
                    end else begin
                        cmd.load_coef = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land in the accumulators and for the output register to be free
                if (status.pipe_empty && status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/sfir_datapath.sv -----
// coefficient and delay-line memories, shared mac per channel, output register
`include "stereo_fir_filter_macros.svh"

module sfir_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sfir_pkg::sfir_cmd_t                    cmd,
    output sfir_pkg::sfir_status_t                 status,
    input  logic [sfir_pkg::TAP_W-1:0]             tap_index,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   left_value,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   right_value,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [sfir_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [1:0]                             m_tuser
);
    import sfir_pkg::*;

    // pointers and valid bits of the delay lines
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [TAPS-1:0]  hist_valid_reg;
    logic [IDX_W-1:0] coef_addr_reg;
    logic [IDX_W-1:0] hist_addr_reg;

    // pipeline
    logic                          rd_valid_reg;
    logic                          hist_ok_reg;
    logic                          mul_valid_reg;
    logic [2*SAMPLE_W-1:0]         coef_rd;
    logic [2*SAMPLE_W-1:0]         hist_rd;
    logic signed [SAMPLE_W-1:0]    hist_l;
    logic signed [SAMPLE_W-1:0]    hist_r;
    logic signed [PROD_W-1:0]      prod_l_next;
    logic signed [PROD_W-1:0]      prod_r_next;
    logic signed [PROD_W-1:0]      prod_l_reg;
    logic signed [PROD_W-1:0]      prod_r_reg;
    logic signed [ACC_W-1:0]       acc_l_reg;
    logic signed [ACC_W-1:0]       acc_r_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [M_TDATA_W-1:0]          m_tdata_reg;
    logic [1:0]                    m_tuser_reg;
    logic                          ovf_l;
    logic                          ovf_r;
    logic                          coef_we;

    assign ptr_next = (ptr_reg == IDX_W'(TAPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign coef_we  = cmd.load_coef && (int'(tap_index) < TAPS);

    sfir_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(TAPS)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (IDX_W'(tap_index)),
        .wdata ({right_value, left_value}),
        .raddr (coef_addr_reg),
        .rdata (coef_rd)
    );

    sfir_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(TAPS)) u_hist_ram (
        .aclk  (aclk),
        .we    (cmd.push_sample),
        .waddr (ptr_next),
        .wdata ({right_value, left_value}),
        .raddr (hist_addr_reg),
        .rdata (hist_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            hist_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            mul_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.push_sample) begin
                ptr_reg                  <= ptr_next;
                hist_valid_reg[ptr_next] <= 1'b1;
            end
            rd_valid_reg  <= cmd.issue;
            mul_valid_reg <= rd_valid_reg;
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // unwritten history entries read as zero
    assign hist_l = hist_ok_reg ? hist_rd[SAMPLE_W-1:0] : '0;
    assign hist_r = hist_ok_reg ? hist_rd[2*SAMPLE_W-1:SAMPLE_W] : '0;
    assign prod_l_next = $signed(coef_rd[SAMPLE_W-1:0]) * hist_l;
    assign prod_r_next = $signed(coef_rd[2*SAMPLE_W-1:SAMPLE_W]) * hist_r;

    always_ff @(posedge aclk) begin
        if (cmd.push_sample) begin
            coef_addr_reg <= '0;
            hist_addr_reg <= ptr_next;
        end else if (cmd.issue) begin
            coef_addr_reg <= coef_addr_reg + 1'b1;
            // walk back through the delay line
            hist_addr_reg <= (hist_addr_reg == '0) ? IDX_W'(TAPS - 1) : hist_addr_reg - 1'b1;
        end
        hist_ok_reg <= hist_valid_reg[hist_addr_reg];
        prod_l_reg  <= prod_l_next;
        prod_r_reg  <= prod_r_next;
        if (cmd.push_sample) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (mul_valid_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
        if (cmd.publish) begin
            m_tdata_reg <= {acc_r_reg[RES_W-1:0], acc_l_reg[RES_W-1:0]};
            m_tuser_reg <= {ovf_r, ovf_l};
        end
    end

    // sum leaves int32 when the bits above the sign are not all copies of it
    assign ovf_l = ~((&acc_l_reg[ACC_W-1:RES_W-1]) | ~(|acc_l_reg[ACC_W-1:RES_W-1]));
    assign ovf_r = ~((&acc_r_reg[ACC_W-1:RES_W-1]) | ~(|acc_r_reg[ACC_W-1:RES_W-1]));

    assign status.last_tap   = (coef_addr_reg == IDX_W'(TAPS - 1));
    assign status.pipe_empty = !rd_valid_reg && !mul_valid_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SFIR_ASSERT_NXT(a_mul_follows_read, rd_valid_reg, mul_valid_reg, "product stage lost a read")
    `SFIR_ASSERT_IMP(a_publish_drained, cmd.publish, status.pipe_empty, "publish before drain")
    `SFIR_ASSERT_IMP(a_push_idle_pipe, cmd.push_sample, !mul_valid_reg && !cmd.issue, "mac busy")
    `SFIR_ASSERT_NXT(a_acc_cleared, cmd.push_sample, (acc_l_reg | acc_r_reg) == '0, "no clear")

endmodule

// ----- rtl/core/stereo_fir_filter.sv -----
// stereo fir filter top level: controller plus mac datapath
//
// channel  dir  tdata (low bit up)                                 tuser
// s_       in   tap_index[5:0] left_value[21:6] right_value[37:22]  command
// m_       out  left_result[31:0] right_result[63:32]               left_ovf[0] right_ovf[1]
//
// a load item is taken in the idle state and ends there; a sample item is worked off by
// one multiply-accumulate per channel stepping through the taps
// the delay-line valid bits are cleared by reset at once, no clearing pass
// a finished result waits in the output register; the next item is taken meanwhile,
// but a sample result is held in the mac until the output register is free
module stereo_fir_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfir_pkg::S_TDATA_W-1:0]   s_tdata,   // tap_index, left_value, right_value
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfir_pkg::M_TDATA_W-1:0]   m_tdata,   // left_result, right_result
    output logic [1:0]                       m_tuser    // left_overflow, right_overflow
);
    import sfir_pkg::*;

    sfir_cmd_t    cmd;
    sfir_status_t status;

    logic [TAP_W-1:0]           tap_index;
    logic signed [SAMPLE_W-1:0] left_value;
    logic signed [SAMPLE_W-1:0] right_value;

    assign tap_index   = s_tdata[TAP_W-1:0];
    assign left_value  = s_tdata[TAP_W+SAMPLE_W-1:TAP_W];
    assign right_value = s_tdata[TAP_W+2*SAMPLE_W-1:TAP_W+SAMPLE_W];

    sfir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_command (s_tuser),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sfir_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .tap_index   (tap_index),
        .left_value  (left_value),
        .right_value (right_value),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- tb/stereo_fir_filter_test.sv -----
// self-checking testbench for the stereo fir filter
module stereo_fir_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfir_pkg::*;

    localparam int RANDOM_ITEMS = 1760;
    localparam int DRAIN_CYCLES = TAPS + 16;

    typedef struct packed {
        logic                       cmd;
        logic [TAP_W-1:0]           tap;
        logic signed [SAMPLE_W-1:0] lv;
        logic signed [SAMPLE_W-1:0] rv;
    } fir_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] left_sum;
        logic signed [RES_W-1:0] right_sum;
        logic                    left_ovf;
        logic                    right_ovf;
    } fir_sum_t;

    typedef struct packed {
        fir_item_t item;
        logic      fixed;
        fir_sum_t  sum;
    } directed_row_t;

    localparam fir_sum_t NO_SUM = '0;

    // fixed sums hold where the row's arithmetic is plain to see; the rest go to the predictor
    localparam int DIRECTED_ROWS = 22;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{CMD_SAMPLE, 6'd0,  16'sh7FFF, 16'sh8000}, 1'b1, NO_SUM},
        '{'{CMD_LOAD,   6'd0,  16'sh8000, 16'sh7FFF}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd63, 16'sh8000, 16'sh8000}, 1'b1,
          '{32'sh4000_0000, 32'shC000_8000, 1'b0, 1'b0}},
        '{'{CMD_LOAD,   6'd1,  16'sh8000, 16'sh8000}, 1'b0, NO_SUM},
        // left sum reaches exactly 2^31
        '{'{CMD_SAMPLE, 6'd0,  16'sh8000, 16'sh7FFF}, 1'b1,
          '{32'sh8000_0000, 32'sh7FFF_0001, 1'b1, 1'b0}},
        '{'{CMD_LOAD,   6'd63, 16'sh7FFF, 16'sh8000}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd2,  16'sh7FFF, 16'sh7FFF}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'sh7FFF, 16'sh7FFF}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd63, 16'sh0000, 16'sh0000}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd21, 16'shFFFF, 16'shFFFF}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd0,  16'sh0001, 16'shFFFF}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd1,  16'sh0000, 16'sh0000}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd42, 16'sh0001, 16'shFFFF}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd32, 16'sh8000, 16'sh8000}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd21, 16'sh3039, 16'shCFC7}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd42, 16'shAAAA, 16'sh5555}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'sh5555, 16'shAAAA}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'shAAAA, 16'sh5555}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'sh8000, 16'sh8000}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'sh7FFF, 16'sh7FFF}, 1'b0, NO_SUM},
        '{'{CMD_LOAD,   6'd0,  16'sh0000, 16'sh0000}, 1'b0, NO_SUM},
        '{'{CMD_SAMPLE, 6'd0,  16'sh0000, 16'sh0000}, 1'b0, NO_SUM}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = CMD_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    // predictor state
    logic signed [SAMPLE_W-1:0] coef_l [TAPS];
    logic signed [SAMPLE_W-1:0] coef_r [TAPS];
    logic signed [SAMPLE_W-1:0] hist_l [TAPS];
    logic signed [SAMPLE_W-1:0] hist_r [TAPS];
    logic [IDX_W-1:0]           newest_ptr = '0;

    fir_sum_t pending_sums [$];
    int       errors     = 0;
    int       burst_left = 0;

    stereo_fir_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("stereo_fir_filter: mismatch");
        $finish;
    end

    function automatic longint tap_sum(bit right_ch);
        longint           acc;
        logic [IDX_W-1:0] idx;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            idx = newest_ptr - IDX_W'(k);
            if (right_ch)
                acc += longint'(coef_r[k]) * longint'(hist_r[idx]);
            else
                acc += longint'(coef_l[k]) * longint'(hist_l[idx]);
        end
        return acc;
    endfunction

    // updates the filter state and returns the sums a sample item produces
    function automatic fir_sum_t filter_step(fir_item_t it);
        fir_sum_t s;
        longint   acc_l;
        longint   acc_r;
        s = NO_SUM;
        if (it.cmd == CMD_LOAD) begin
            coef_l[it.tap] = it.lv;
            coef_r[it.tap] = it.rv;
        end else begin
            newest_ptr = newest_ptr + 1'b1;
            hist_l[newest_ptr] = it.lv;
            hist_r[newest_ptr] = it.rv;
            acc_l = tap_sum(1'b0);
            acc_r = tap_sum(1'b1);
            s.left_sum  = acc_l[RES_W-1:0];
            s.right_sum = acc_r[RES_W-1:0];
            s.left_ovf  = acc_l != longint'($signed(acc_l[RES_W-1:0]));
            s.right_ovf = acc_r != longint'($signed(acc_r[RES_W-1:0]));
        end
        return s;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return SAMPLE_W'($urandom);
        else if (r < 8)
            return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
        else if (r == 8)
            return 16'sh8000;
        else
            return 16'sh7FFF;
    endfunction

    task automatic drive_item(fir_item_t it, logic fixed, fir_sum_t fixed_sum);
        fir_sum_t predicted;
        int       gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({it.rv, it.lv, it.tap});
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        predicted = filter_step(it);
        if (it.cmd == CMD_SAMPLE)
            pending_sums.push_back(fixed ? fixed_sum : predicted);
        // burst and gap pattern of the sender
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    // receiver stall pattern
    initial begin
        int unsigned mode;
        int unsigned span;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 300);
            for (int c = 0; c < span; c++) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (c % 48) >= $urandom_range(30, 40);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        fir_sum_t exp_sum;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_sum = pending_sums.pop_front();
                if ($signed(m_tdata[RES_W-1:0]) !== exp_sum.left_sum) begin
                    $display("%0t: left_result expected %0d actual %0d", $time,
                             exp_sum.left_sum, $signed(m_tdata[RES_W-1:0]));
                    errors++;
                end
                if ($signed(m_tdata[2*RES_W-1:RES_W]) !== exp_sum.right_sum) begin
                    $display("%0t: right_result expected %0d actual %0d", $time,
                             exp_sum.right_sum, $signed(m_tdata[2*RES_W-1:RES_W]));
                    errors++;
                end
                if (m_tuser[0] !== exp_sum.left_ovf) begin
                    $display("%0t: left_overflow expected %b actual %b", $time,
                             exp_sum.left_ovf, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_sum.right_ovf) begin
                    $display("%0t: right_overflow expected %b actual %b", $time,
                             exp_sum.right_ovf, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        fir_item_t it;
        for (int k = 0; k < TAPS; k++) begin
            coef_l[k] = '0;
            coef_r[k] = '0;
            hist_l[k] = '0;
            hist_r[k] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every tap gets a coefficient before the first sample item
        for (int k = 0; k < TAPS; k++)
            drive_item('{CMD_LOAD, TAP_W'(k), 16'sh0000, 16'sh0000}, 1'b0, NO_SUM);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            drive_item(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].sum);
        wait_results_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            it.cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_SAMPLE;
            it.tap = TAP_W'($urandom_range(0, TAPS - 1));
            it.lv  = pick_value();
            it.rv  = pick_value();
            drive_item(it, 1'b0, NO_SUM);
            if (i == RANDOM_ITEMS / 2)
                wait_results_drained();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_sums.size() != 0) begin
            $display("%0t: %0d items expected, actual none", $time, pending_sums.size());
            errors++;
        end
        if (errors == 0)
            $display("stereo_fir_filter: match");
        else
            $display("stereo_fir_filter: mismatch");
        $finish;
    end

endmodule
